// ===== sv/swfa_pkg.sv =====
// shared types and constants for the spin window frequency adjust block
package swfa_pkg;

   localparam int WINDOW_BITS = 8;
   localparam int SCALE_BITS  = 8;
   localparam int LEVEL_BITS  = WINDOW_BITS + SCALE_BITS;
   localparam int DELTA_BITS  = 9;
   localparam int QUO_BITS    = 8;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 8;

   localparam logic [CSR_IDX_BITS-1:0] CSR_INC_SCALE  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEC_SCALE  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CORE_COUNT = 2'd2;

   localparam logic [SCALE_BITS-1:0]  INC_SCALE_RST  = 8'd1;
   localparam logic [SCALE_BITS-1:0]  DEC_SCALE_RST  = 8'd1;
   localparam logic [WINDOW_BITS-1:0] CORE_COUNT_RST = 8'd8;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_INC_CHK = 6'b000010,
      ST_DIV     = 6'b000100,
      ST_FIN     = 6'b001000,
      ST_DEC_CHK = 6'b010000,
      ST_OUT     = 6'b100000
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic div_step;
      logic fin;
      logic dec_side;
      logic push;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic inc_hit;
      logic dec_hit;
   } status_type;

endpackage

// ===== sv/swfa_ctrl.sv =====
// sequencing state machine for the spin window frequency adjust block
module swfa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  swfa_pkg::status_type status,
   output swfa_pkg::cmd_type    cmd
);
   import swfa_pkg::*;

   state_type             state_ff, state_in;
   logic [2:0]            cnt_ff, cnt_in;
   logic                  side_ff, side_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      side_in      = side_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmd          = '0;
      cmd.dec_side = side_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_INC_CHK;
            end
         end
         ST_INC_CHK: begin
            if (status.skip) begin
               state_in = ST_OUT;
            end else if (status.inc_hit) begin
               side_in      = 1'b0;
               cmd.dec_side = 1'b0;
               cmd.mul      = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV;
            end else begin
               state_in = ST_DEC_CHK;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = side_ff ? ST_OUT : ST_DEC_CHK;
         end
         ST_DEC_CHK: begin
            if (status.dec_hit) begin
               side_in      = 1'b1;
               cmd.dec_side = 1'b1;
               cmd.mul      = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // output slot free or being emptied this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.push     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         side_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         side_ff      <= side_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/swfa_dpath.sv =====
// counters, trigger compare, divider and delta limiting for the adjust block
module swfa_dpath #(
   parameter int COUNT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [swfa_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [swfa_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   input  logic                                 req_slept,
   input  logic                                 req_spun,
   input  logic                                 req_window_updated,
   input  logic [swfa_pkg::WINDOW_BITS-1:0]     req_window_size,
   input  swfa_pkg::cmd_type                    cmd,
   output swfa_pkg::status_type                 status,
   output logic signed [swfa_pkg::DELTA_BITS-1:0] rsp_delta,
   output logic                                 rsp_apply
);
   import swfa_pkg::*;

   localparam int CB = COUNT_BITS;
   localparam int NW = CB + WINDOW_BITS;
   localparam int RW = CB + 2;
   localparam int CW = CB + LEVEL_BITS + 2;
   localparam logic signed [CB-1:0] HMAX = {1'b0, {(CB-1){1'b1}}};
   localparam logic signed [CB-1:0] HMIN = {1'b1, {(CB-1){1'b0}}};
   localparam logic [CB-1:0]        UMAX = {CB{1'b1}};

   logic [SCALE_BITS-1:0]         inc_scale_ff, inc_scale_in;
   logic [SCALE_BITS-1:0]         dec_scale_ff, dec_scale_in;
   logic [WINDOW_BITS-1:0]        core_ff, core_in;

   logic signed [CB-1:0]          heur_ff, heur_in;
   logic [CB-1:0]                 late_ff, late_in;
   logic [CB-1:0]                 early_ff, early_in;

   logic [WINDOW_BITS-1:0]        window_ff, window_in;
   logic                          skip_ff, skip_in;
   logic [LEVEL_BITS-1:0]         inc_level_ff, inc_level_in;
   logic [LEVEL_BITS-1:0]         dec_level_ff, dec_level_in;

   logic [7:0]                    n_lo_ff, n_lo_in;
   logic [CB:0]                   total_ff, total_in;
   logic [RW-1:0]                 rem_ff, rem_in;
   logic [QUO_BITS-1:0]           quo_ff, quo_in;
   logic signed [DELTA_BITS-1:0]  delta_ff, delta_in;
   logic signed [DELTA_BITS-1:0]  rsp_delta_ff, rsp_delta_in;
   logic                          rsp_apply_ff, rsp_apply_in;

   logic signed [CW-1:0]          heur_ext, inc_ext, dec_ext;
   logic [CB-1:0]                 part;
   logic [NW-1:0]                 prod;
   logic [RW-1:0]                 shifted, tot_ext;
   logic [QUO_BITS-1:0]           q_eff;
   logic [DELTA_BITS-1:0]         win_x, q_x, core_x, sum_x;

   // trigger compare in a width that holds both the counter and the level
   assign heur_ext = CW'(heur_ff);
   assign inc_ext  = signed'(CW'(inc_level_ff));
   assign dec_ext  = signed'(CW'(dec_level_ff));

   assign status.skip    = skip_ff;
   assign status.inc_hit = (heur_ext == inc_ext);
   assign status.dec_hit = (heur_ext == -dec_ext);

   assign part    = cmd.dec_side ? early_ff : late_ff;
   assign prod    = NW'(window_ff) * NW'(part);
   assign tot_ext = RW'(total_ff);
   assign shifted = {rem_ff[RW-2:0], n_lo_ff[7]};
   assign q_eff   = (total_ff == '0) ? '0 : quo_ff;
   assign win_x   = {1'b0, window_ff};
   assign q_x     = {1'b0, q_eff};
   assign core_x  = {1'b0, core_ff};
   assign sum_x   = win_x + q_x;

   always_comb begin
      inc_scale_in = inc_scale_ff;
      dec_scale_in = dec_scale_ff;
      core_in      = core_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_INC_SCALE:  inc_scale_in = csr_write_data;
            CSR_DEC_SCALE:  dec_scale_in = csr_write_data;
            CSR_CORE_COUNT: core_in      = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      heur_in      = heur_ff;
      late_in      = late_ff;
      early_in     = early_ff;
      window_in    = window_ff;
      skip_in      = skip_ff;
      inc_level_in = inc_level_ff;
      dec_level_in = dec_level_ff;
      n_lo_in      = n_lo_ff;
      total_in     = total_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      delta_in     = delta_ff;
      rsp_delta_in = rsp_delta_ff;
      rsp_apply_in = rsp_apply_ff;

      if (cmd.load) begin
         window_in    = req_window_size;
         skip_in      = req_window_updated;
         inc_level_in = LEVEL_BITS'(req_window_size) * LEVEL_BITS'(inc_scale_ff);
         dec_level_in = LEVEL_BITS'(req_window_size) * LEVEL_BITS'(dec_scale_ff);
         delta_in     = '0;
         if (!req_window_updated) begin
            // late event: slept without spinning
            if (req_slept && !req_spun) begin
               if (heur_ff != HMAX) heur_in = heur_ff + CB'(1);
               if (late_ff != UMAX) late_in = late_ff + CB'(1);
            end
            // early event: spun without sleeping
            if (!req_slept && req_spun) begin
               if (heur_ff != HMIN) heur_in  = heur_ff - CB'(1);
               if (early_ff != UMAX) early_in = early_ff + CB'(1);
            end
         end
      end

      if (cmd.mul) begin
         // quotient fits in 8 bits, so the upper dividend bits seed the remainder
         n_lo_in  = prod[7:0];
         rem_in   = RW'(prod[NW-1:8]);
         total_in = {1'b0, late_ff} + {1'b0, early_ff};
         quo_in   = '0;
      end

      if (cmd.div_step) begin
         n_lo_in = {n_lo_ff[6:0], 1'b0};
         if (shifted >= tot_ext) begin
            rem_in = shifted - tot_ext;
            quo_in = {quo_ff[QUO_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[QUO_BITS-2:0], 1'b0};
         end
      end

      if (cmd.fin) begin
         if (cmd.dec_side) begin
            // keep window + delta at least one
            if (q_eff >= window_ff) delta_in = signed'(DELTA_BITS'(1) - win_x);
            else delta_in = signed'(-q_x);
         end else begin
            // cap window + delta at the core count
            if (sum_x > core_x) delta_in = signed'(core_x - win_x);
            else delta_in = signed'(q_x);
         end
         heur_in  = '0;
         late_in  = '0;
         early_in = '0;
      end

      if (cmd.push) begin
         rsp_delta_in = delta_ff;
         rsp_apply_in = (delta_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_scale_ff <= INC_SCALE_RST;
         dec_scale_ff <= DEC_SCALE_RST;
         core_ff      <= CORE_COUNT_RST;
         heur_ff      <= '0;
         late_ff      <= '0;
         early_ff     <= '0;
      end else begin
         inc_scale_ff <= inc_scale_in;
         dec_scale_ff <= dec_scale_in;
         core_ff      <= core_in;
         heur_ff      <= heur_in;
         late_ff      <= late_in;
         early_ff     <= early_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff    <= window_in;
      skip_ff      <= skip_in;
      inc_level_ff <= inc_level_in;
      dec_level_ff <= dec_level_in;
      n_lo_ff      <= n_lo_in;
      total_ff     <= total_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      delta_ff     <= delta_in;
      rsp_delta_ff <= rsp_delta_in;
      rsp_apply_ff <= rsp_apply_in;
   end

   assign rsp_delta = rsp_delta_ff;
   assign rsp_apply = rsp_apply_ff;

endmodule

// ===== sv/spin_window_freq_adjust.sv =====
// spin window frequency adjust: top level
// Takes one lock-acquisition report per req_ transaction and returns one rsp_
// transaction holding the signed window delta and an apply flag.
// Both channels are valid/stall: a transaction moves on a rising edge with
// valid high and stall low. req_stall is high while an item is in progress.
// A skipped item goes from the increase check straight to the output state.
// Otherwise it passes the increase check and the decrease check, and each
// trigger that fires adds the divider steps and a finish step before the
// output state. The fraction window*events/total is computed, once the
// product is registered, in a radix-2 divider: one quotient bit a cycle.
// The finished result waits in an output register; while rsp_stall is high
// the result holds and the next item cannot finish, so req_stall stays high.
// Reset (synchronous) clears the heuristic counter and event counts and
// loads increase_scale = 1, decrease_scale = 1, core_count = 8.
// csr_ writes are taken on any edge with csr_write_en high and are meant for
// idle periods only; index 3 is ignored.
module spin_window_freq_adjust #(
   parameter int COUNT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [swfa_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [swfa_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_slept,
   input  logic                                 req_spun,
   input  logic                                 req_window_updated,
   input  logic [swfa_pkg::WINDOW_BITS-1:0]     req_window_size,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [swfa_pkg::DELTA_BITS-1:0] rsp_delta,
   output logic                                 rsp_apply
);
   import swfa_pkg::*;

   cmd_type    cmd;
   status_type status;

   swfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   swfa_dpath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_slept          (req_slept),
      .req_spun           (req_spun),
      .req_window_updated (req_window_updated),
      .req_window_size    (req_window_size),
      .cmd                (cmd),
      .status             (status),
      .rsp_delta          (rsp_delta),
      .rsp_apply          (rsp_apply)
   );

endmodule

// ===== verif/tb_spin_window_freq_adjust.sv =====
// self-checking testbench for the spin window frequency adjust block
`timescale 1ns / 100ps

module tb_spin_window_freq_adjust;
   import swfa_pkg::*;

   localparam int COUNT_BITS = 16;
   localparam int HEUR_MAX = (1 << (COUNT_BITS - 1)) - 1;
   localparam int HEUR_MIN = -HEUR_MAX - 1;
   localparam int unsigned EVENT_MAX = (1 << COUNT_BITS) - 1;
   localparam int SETTLE_CYCLES = 3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {ACT_ITEM, ACT_CSR, ACT_PAUSE} act_kind_type;

   typedef struct {
      act_kind_type kind;
      logic slept;
      logic spun;
      logic skip;
      logic [WINDOW_BITS-1:0] win;
      logic [CSR_IDX_BITS-1:0] idx;
      logic [CSR_DATA_BITS-1:0] data;
      bit calm;
   } action_type;

   typedef struct packed {
      logic signed [DELTA_BITS-1:0] delta;
      logic apply;
   } adj_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_slept = 1'b0;
   logic req_spun = 1'b0;
   logic req_window_updated = 1'b0;
   logic [WINDOW_BITS-1:0] req_window_size = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [DELTA_BITS-1:0] rsp_delta;
   logic rsp_apply;

   spin_window_freq_adjust #(.COUNT_BITS(COUNT_BITS)) dut (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_slept(req_slept),
      .req_spun(req_spun),
      .req_window_updated(req_window_updated),
      .req_window_size(req_window_size),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_delta(rsp_delta),
      .rsp_apply(rsp_apply)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   action_type pending_actions[$];
   adj_type expected_adj[$];
   int err_cnt = 0;
   int gap_cnt = 0;
   int hold_cnt = 0;
   int settle_cnt = 0;
   bit no_idle = 1'b0;

   // predicted block state and register copies
   int heur_cnt;
   int unsigned late_cnt;
   int unsigned early_cnt;
   logic [SCALE_BITS-1:0] cfg_inc_scale;
   logic [SCALE_BITS-1:0] cfg_dec_scale;
   logic [WINDOW_BITS-1:0] cfg_core_count;

   // stimulus-side view of the heuristic counter, used to aim at trigger levels
   int gen_heur = 0;
   int gen_inc = 1;
   int gen_dec = 1;
   int live_items = 0;
   bit gen_calm = 1'b0;

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      err_cnt++;
   endtask

   function automatic int window_share(input logic [WINDOW_BITS-1:0] win,
                                       input int unsigned part);
      longint unsigned total;
      total = longint'(late_cnt) + longint'(early_cnt);
      if (total == 0) return 0;
      return int'((longint'(win) * longint'(part)) / total);
   endfunction

   function automatic void clear_counts();
      heur_cnt = 0;
      late_cnt = 0;
      early_cnt = 0;
   endfunction

   function automatic adj_type predict_adjust(input logic slept, input logic spun,
                                              input logic skip,
                                              input logic [WINDOW_BITS-1:0] win);
      adj_type res;
      int d;
      int w;
      d = 0;
      w = int'(win);
      if (!skip) begin
         if (slept && !spun) begin
            if (heur_cnt < HEUR_MAX) heur_cnt++;
            if (late_cnt < EVENT_MAX) late_cnt++;
         end
         if (!slept && spun) begin
            if (heur_cnt > HEUR_MIN) heur_cnt--;
            if (early_cnt < EVENT_MAX) early_cnt++;
         end
         if (heur_cnt == w * int'(cfg_inc_scale)) begin
            d = window_share(win, late_cnt);
            if (w + d > int'(cfg_core_count)) d = int'(cfg_core_count) - w;
            clear_counts();
         end
         // checked after the increase; a hit here overrides its delta
         if (heur_cnt == -(w * int'(cfg_dec_scale))) begin
            d = -window_share(win, early_cnt);
            if (w + d < 1) d = 1 - w;
            clear_counts();
         end
      end
      res.delta = d[DELTA_BITS-1:0];
      res.apply = (d != 0);
      return res;
   endfunction

   function automatic bit push_item(input logic slept, input logic spun, input logic skip,
                                    input logic [WINDOW_BITS-1:0] win);
      action_type a;
      bit fired;
      a = '{kind: ACT_ITEM, slept: slept, spun: spun, skip: skip, win: win,
            idx: '0, data: '0, calm: gen_calm};
      pending_actions.push_back(a);
      fired = 1'b0;
      if (!skip) begin
         live_items++;
         if (slept && !spun) gen_heur++;
         if (!slept && spun) gen_heur--;
         if (gen_heur == int'(win) * gen_inc) begin
            gen_heur = 0;
            fired = 1'b1;
         end
         if (gen_heur == -(int'(win) * gen_dec)) begin
            gen_heur = 0;
            fired = 1'b1;
         end
      end
      return fired;
   endfunction

   task automatic push_csr(input logic [CSR_IDX_BITS-1:0] idx,
                           input logic [CSR_DATA_BITS-1:0] data);
      action_type a;
      a = '{kind: ACT_CSR, slept: 1'b0, spun: 1'b0, skip: 1'b0, win: '0,
            idx: idx, data: data, calm: gen_calm};
      pending_actions.push_back(a);
      if (idx == CSR_INC_SCALE) gen_inc = int'(data);
      if (idx == CSR_DEC_SCALE) gen_dec = int'(data);
   endtask

   task automatic push_pause();
      action_type a;
      a = '{kind: ACT_PAUSE, slept: 1'b0, spun: 1'b0, skip: 1'b0, win: '0,
            idx: '0, data: '0, calm: gen_calm};
      pending_actions.push_back(a);
   endtask

   // runs of events aimed at a trigger level, with noise mixed in
   task automatic run_phase(input logic [SCALE_BITS-1:0] inc, input logic [SCALE_BITS-1:0] dec,
                            input logic [WINDOW_BITS-1:0] cores, input int n,
                            input int max_need);
      int stop_at;
      int w;
      int need_up;
      int need_dn;
      int need;
      int steps;
      int r;
      logic s;
      bit up_ok;
      bit dn_ok;
      bit go_up;
      bit fired;
      push_csr(CSR_INC_SCALE, inc);
      push_csr(CSR_DEC_SCALE, dec);
      push_csr(CSR_CORE_COUNT, cores);
      stop_at = live_items + n;
      while (live_items < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            void'(push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            $urandom_range(0, 3) == 0,
                            WINDOW_BITS'($urandom_range(0, 255))));
            if ($urandom_range(0, 3) == 0) push_pause();
         end else begin
            r = $urandom_range(0, 99);
            if (r < 10) w = 0;
            else if (r < 75) w = $urandom_range(1, 6);
            else w = $urandom_range(0, 255);
            need_up = w * gen_inc - gen_heur;
            need_dn = gen_heur + w * gen_dec;
            up_ok = (need_up >= 1) && (need_up <= max_need);
            dn_ok = (need_dn >= 1) && (need_dn <= max_need);
            if (!up_ok && !dn_ok) begin
               s = 1'($urandom_range(0, 1));
               void'(push_item(s, s, 1'b0, WINDOW_BITS'(w)));
            end else begin
               go_up = up_ok && (!dn_ok || $urandom_range(0, 1) == 1);
               need = go_up ? need_up : need_dn;
               steps = 0;
               fired = 1'b0;
               while (!fired && steps < need + 16) begin
                  r = $urandom_range(0, 99);
                  if (r < 6) begin
                     fired = push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                       1'b1, WINDOW_BITS'($urandom_range(0, 255)));
                  end else if (r < 12) begin
                     s = 1'($urandom_range(0, 1));
                     fired = push_item(s, s, 1'b0, WINDOW_BITS'(w));
                  end else if (r < 17) begin
                     fired = push_item(!go_up, go_up, 1'b0, WINDOW_BITS'(w));
                  end else begin
                     fired = push_item(go_up, !go_up, 1'b0, WINDOW_BITS'(w));
                  end
                  steps++;
               end
            end
         end
      end
   endtask

   // request driver
   always @(posedge clock) begin : req_driver
      action_type act;
      adj_type guess;
      logic next_valid;
      logic next_we;
      if (reset) begin
         req_valid <= 1'b0;
         csr_write_en <= 1'b0;
         gap_cnt = 0;
         settle_cnt = 0;
         cfg_inc_scale = INC_SCALE_RST;
         cfg_dec_scale = DEC_SCALE_RST;
         cfg_core_count = CORE_COUNT_RST;
         clear_counts();
      end else begin
         next_valid = req_valid;
         next_we = 1'b0;
         if (req_valid && !req_stall) begin
            guess = predict_adjust(req_slept, req_spun, req_window_updated, req_window_size);
            expected_adj.push_back(guess);
            next_valid = 1'b0;
         end
         if (expected_adj.size() == 0 && !req_valid) settle_cnt++;
         else settle_cnt = 0;
         if (!next_valid) begin
            if (gap_cnt > 0) begin
               gap_cnt--;
            end else if (pending_actions.size() > 0) begin
               act = pending_actions[0];
               case (act.kind)
                  ACT_ITEM: begin
                     void'(pending_actions.pop_front());
                     next_valid = 1'b1;
                     req_slept <= act.slept;
                     req_spun <= act.spun;
                     req_window_updated <= act.skip;
                     req_window_size <= act.win;
                     no_idle = act.calm;
                     if (!act.calm && $urandom_range(0, 4) == 0) gap_cnt = $urandom_range(1, 3);
                  end
                  ACT_CSR: begin
                     // registers change only with nothing in flight
                     if (settle_cnt >= SETTLE_CYCLES) begin
                        void'(pending_actions.pop_front());
                        next_we = 1'b1;
                        csr_index <= act.idx;
                        csr_write_data <= act.data;
                        case (act.idx)
                           CSR_INC_SCALE: cfg_inc_scale = act.data;
                           CSR_DEC_SCALE: cfg_dec_scale = act.data;
                           CSR_CORE_COUNT: cfg_core_count = act.data;
                           default: ;
                        endcase
                     end
                  end
                  ACT_PAUSE: begin
                     if (expected_adj.size() == 0) void'(pending_actions.pop_front());
                  end
                  default: ;
               endcase
            end
         end
         req_valid <= next_valid;
         csr_write_en <= next_we;
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin : rsp_monitor
      adj_type want;
      logic next_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cnt = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_adj.size() == 0) begin
               report_error($sformatf("unexpected transaction delta=%0d apply=%b",
                                      rsp_delta, rsp_apply));
            end else begin
               want = expected_adj.pop_front();
               if (rsp_delta !== want.delta)
                  report_error($sformatf("delta got %0d want %0d", rsp_delta, want.delta));
               if (rsp_apply !== want.apply)
                  report_error($sformatf("apply got %b want %b", rsp_apply, want.apply));
            end
         end
         next_stall = 1'b0;
         if (hold_cnt > 0) begin
            hold_cnt--;
            next_stall = 1'b1;
         end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            hold_cnt = $urandom_range(0, 2);
            next_stall = 1'b1;
         end
         rsp_stall <= next_stall;
      end
   end

   initial begin : stimulus
      // reset settings: increase 1, decrease 1, cores 8
      void'(push_item(1'b1, 1'b0, 1'b1, 8'd5));      // skipped
      void'(push_item(1'b0, 1'b1, 1'b1, 8'd0));      // skipped, zero window
      void'(push_item(1'b0, 1'b0, 1'b0, 8'd0));      // both levels zero, decrease floor
      void'(push_item(1'b1, 1'b1, 1'b0, 8'd255));    // both flags, no change
      void'(push_item(1'b1, 1'b0, 1'b0, 8'd1));
      void'(push_item(1'b0, 1'b1, 1'b0, 8'd1));
      void'(push_item(1'b0, 1'b1, 1'b0, 8'd2));
      void'(push_item(1'b0, 1'b1, 1'b0, 8'd2));
      void'(push_item(1'b1, 1'b0, 1'b0, 8'd3));
      void'(push_item(1'b1, 1'b0, 1'b0, 8'd3));
      void'(push_item(1'b0, 1'b1, 1'b0, 8'd3));
      void'(push_item(1'b1, 1'b0, 1'b0, 8'd3));
      void'(push_item(1'b1, 1'b0, 1'b0, 8'd3));      // fraction 4/5 of the window
      void'(push_item(1'b1, 1'b1, 1'b1, 8'd255));
      push_pause();
      // window above the core count
      push_csr(CSR_CORE_COUNT, 8'd1);
      void'(push_item(1'b1, 1'b0, 1'b0, 8'd2));
      void'(push_item(1'b1, 1'b0, 1'b0, 8'd2));
      // zero increase scale and zero cores: delta is minus the window
      push_csr(CSR_INC_SCALE, 8'd0);
      push_csr(CSR_CORE_COUNT, 8'd0);
      push_csr(CSR_UNUSED, 8'hff);
      void'(push_item(1'b0, 1'b0, 1'b0, 8'd255));
      void'(push_item(1'b1, 1'b0, 1'b0, 8'd1));
      void'(push_item(1'b0, 1'b1, 1'b0, 8'd1));
      void'(push_item(1'b0, 1'b0, 1'b0, 8'd170));

      run_phase(8'd1, 8'd1, 8'd8, 150, 60);
      run_phase(8'd2, 8'd3, 8'd16, 150, 60);
      run_phase(8'd0, 8'd0, 8'd255, 80, 60);
      run_phase(8'd255, 8'd255, 8'd255, 300, 300);
      run_phase(8'd1, 8'd2, 8'd1, 120, 60);
      run_phase(8'd3, 8'd1, 8'd0, 80, 60);
      run_phase(8'd4, 8'd4, 8'd255, 150, 60);
      gen_calm = 1'b1;
      run_phase(SCALE_BITS'($urandom_range(0, 7)), SCALE_BITS'($urandom_range(0, 7)),
                WINDOW_BITS'($urandom_range(1, 255)), 120, 60);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (pending_actions.size() != 0 || expected_adj.size() != 0 || req_valid)
         @(posedge clock);
      repeat (30) @(posedge clock);
      if (expected_adj.size() != 0)
         report_error($sformatf("%0d expected results never arrived", expected_adj.size()));
      if (err_cnt == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : watchdog
      #3000000;
      $display("simulation failed");
      $finish;
   end

endmodule
